### src/hsec_pkg.sv
`timescale 1ns / 1ps
// Package for the Hamming SEC encoder/decoder: field widths, codes and
// elaboration helpers for check-bit count and length masks. No dependencies.
package hsec_pkg;

    localparam int WORD_W            = 63;  // word_in / word_out width
    localparam int SYN_W             = 6;   // syndrome port width
    localparam int CFG_W             = 6;   // data_bits register width
    localparam int DEF_MAX_CODE_BITS = 63;
    localparam logic [CFG_W-1:0] DATA_BITS_RST = 6'd57;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_BEYOND    = 2'd2
    } t_status;

    // least r with 2^r >= k + r + 1
    function automatic int f_check_count(input int k);
        int r;
        r = 0;
        for (int m = 0; m < 8; m++) begin
            if ((1 << r) < k + r + 1) begin
                r++;
            end
        end
        return r;
    endfunction

    // largest k whose code length fits in maxn positions
    function automatic int f_max_k(input int maxn);
        int best;
        best = 1;
        for (int k = 1; k < 64; k++) begin
            if (k + f_check_count(k) <= maxn) begin
                best = k;
            end
        end
        return best;
    endfunction

    // zero reads as one, then clamp to the largest length that fits
    function automatic logic [CFG_W-1:0] f_eff_k(input logic [CFG_W-1:0] v, input int kmax);
        int k;
        k = int'(v);
        if (k == 0) begin
            k = 1;
        end
        if (k > kmax) begin
            k = kmax;
        end
        return CFG_W'(k);
    endfunction

    // low len bits set
    function automatic logic [WORD_W-1:0] f_mask(input logic [CFG_W-1:0] len);
        logic [WORD_W-1:0] m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (b < int'(len));
        end
        return m;
    endfunction

endpackage

### src/hsec_parity.sv
`timescale 1ns / 1ps
// Syndrome parity trees: bit m is the XOR of all positions whose index has bit m set.
// Depends on nothing but its parameters.
module hsec_parity #(
    parameter int CW = 63,
    parameter int SW = 6
) (
    input  logic [CW-1:0] i_word,   // bit i-1 = position i
    output logic [SW-1:0] o_syn
);

    always_comb begin
        for (int m = 0; m < SW; m++) begin
            o_syn[m] = 1'b0;
            for (int i = 1; i <= CW; i++) begin
                if (((i >> m) & 1) == 1) begin
                    o_syn[m] = o_syn[m] ^ i_word[i-1];
                end
            end
        end
    end

endmodule

### src/hamming_sec_encode_decode.sv
`timescale 1ns / 1ps
// Hamming single-error-correcting encoder/decoder, three-stage pipeline.
// Depends on hsec_pkg and hsec_parity.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tdata: word_in[62:0], pad; tuser: opcode
//  m       | out | o_m_tvalid/i_m_tready  | tdata: word_out, syndrome, pad; tuser: status
//  cfg     | in  | i_cfg_we               | i_cfg_data: data_bits
//
// One word per cycle sustained while i_m_tready stays high; an accepted word passes the
// stage 1, stage 2 and stage 3 registers before o_m_tvalid presents its result.
// Stage 1 masks and scatters, stage 2 runs the parity trees, stage 3 corrects,
// gathers and holds the result; the parity tree sets the stage depth.
// Ready ripples back from the output register, so a stall fills the bubbles first
// and then holds every stage; nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and loads data_bits = 57.
module hamming_sec_encode_decode
    import hsec_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,   // data_bits
    // input words
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [63:0]       i_s_tdata,    // [62:0] word_in, [63] zero
    input  logic              i_s_tuser,    // [0] opcode
    // result words
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [71:0]       o_m_tdata,    // [62:0] word_out, [68:63] syndrome, [71:69] zero
    output logic [1:0]        o_m_tuser     // [1:0] status
);

    localparam int CW   = MAX_CODE_BITS;          // codeword positions
    localparam int SW   = $clog2(MAX_CODE_BITS + 1);
    localparam int KMAX = f_max_k(MAX_CODE_BITS);
    localparam logic [CFG_W-1:0] K_RST = f_eff_k(DATA_BITS_RST, KMAX);
    localparam logic [CFG_W-1:0] N_RST = CFG_W'(int'(K_RST) + f_check_count(int'(K_RST)));
    localparam logic [WORD_W-1:0] KMASK_RST = f_mask(K_RST);
    localparam logic [WORD_W-1:0] NMASK_RST = f_mask(N_RST);

    // ---------------- config: keep derived length and masks registered
    logic [CFG_W-1:0] n_k, n_n, r_n;
    logic [CW-1:0]    r_kmask, r_nmask;
    logic [WORD_W-1:0] w_kmask_full, w_nmask_full;

    always_comb begin
        n_k = f_eff_k(i_cfg_data, KMAX);
        n_n = CFG_W'(int'(n_k) + f_check_count(int'(n_k)));
        w_kmask_full = f_mask(n_k);
        w_nmask_full = f_mask(n_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= N_RST;
            r_kmask <= KMASK_RST[CW-1:0];
            r_nmask <= NMASK_RST[CW-1:0];
        end else if (i_cfg_we) begin
            r_n     <= n_n;
            r_kmask <= w_kmask_full[CW-1:0];
            r_nmask <= w_nmask_full[CW-1:0];
        end
    end

    // ---------------- pipeline flow control
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3      = !r_v3 || i_m_tready;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: mask to length, scatter data for encode
    logic [CW-1:0] w_in, w_data, w_scat;
    t_op           r_op1, r_op2;
    logic [CW-1:0] r_s1, r_s2;

    assign w_in   = i_s_tdata[CW-1:0];
    assign w_data = w_in & r_kmask;

    // data bit j goes to the j-th non-power-of-two position
    for (genvar gi = 1; gi <= CW; gi++) begin : g_scat
        if ((gi & (gi - 1)) == 0) begin : g_chk
            assign w_scat[gi-1] = 1'b0;
        end else begin : g_dat
            assign w_scat[gi-1] = w_data[gi - $clog2(gi + 1) - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_op1 <= t_op'(i_s_tuser);
            r_s1  <= (t_op'(i_s_tuser) == OP_DECODE) ? (w_in & r_nmask) : w_scat;
        end
    end

    // ---------------- stage 2: syndrome (encode: check-bit parities)
    logic [SW-1:0] w_syn, r_syn2;

    hsec_parity #(
        .CW (CW),
        .SW (SW)
    ) u_parity (
        .i_word (r_s1),
        .o_syn  (w_syn)
    );

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_op2  <= r_op1;
            r_s2   <= r_s1;
            r_syn2 <= w_syn;
        end
    end

    // ---------------- stage 3: correct, gather, result register
    logic [CW-1:0] w_flip, w_code, w_chk, w_gath;
    logic          w_in_range;
    logic [WORD_W-1:0] n_word, r_word;
    logic [SYN_W-1:0]  n_syn, r_syn;
    t_status           n_status, r_status;

    assign w_in_range = (SYN_W'(r_syn2) <= r_n);

    for (genvar gi = 1; gi <= CW; gi++) begin : g_pos
        assign w_flip[gi-1] = (r_syn2 == SW'(gi)) && w_in_range;
        if ((gi & (gi - 1)) == 0) begin : g_chk
            // check bit m sits at position 2^m
            assign w_chk[gi-1] = r_syn2[$clog2(gi)];
        end else begin : g_dat
            assign w_chk[gi-1] = 1'b0;
        end
    end

    assign w_code = r_s2 ^ w_flip;

    // position i back to data bit j; upper data bits stay zero
    always_comb begin
        w_gath = '0;
        for (int i = 1; i <= CW; i++) begin
            if ((i & (i - 1)) != 0) begin
                w_gath[i - $clog2(i + 1) - 1] = w_code[i-1];
            end
        end
    end

    always_comb begin
        n_word   = '0;
        n_syn    = '0;
        n_status = ST_CLEAN;
        case (r_op2)
            OP_ENCODE: begin
                n_word = WORD_W'(r_s2 | w_chk);
            end
            OP_DECODE: begin
                n_word = WORD_W'(w_gath);
                n_syn  = SYN_W'(r_syn2);
                if (r_syn2 == '0) begin
                    n_status = ST_CLEAN;
                end else if (w_in_range) begin
                    n_status = ST_CORRECTED;
                end else begin
                    n_status = ST_BEYOND;
                end
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_word   <= n_word;
            r_syn    <= n_syn;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {3'b000, r_syn, r_word};
    assign o_m_tuser  = r_status;

    // ---------------- checks
    a_corr_has_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && (r_status == ST_CORRECTED) |-> (r_syn != '0 && r_syn <= r_n))
        else $error("corrected word without in-range syndrome");

    a_clean_no_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && (r_status == ST_CLEAN) |-> (r_syn == '0))
        else $error("clean status with nonzero syndrome");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_en2 |=> r_v2)
        else $error("word lost between stage 1 and stage 2");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_s_tready)
        else $error("input stalled while output register empty");

endmodule

### bench/hsec_checker.sv
`timescale 1ns / 1ps
// Result checker for hamming_sec_encode_decode: tracks data_bits, predicts each
// result word from the accepted input words and compares. Depends on hsec_pkg.
module hsec_checker
    import hsec_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [63:0]       i_s_tdata,    // [62:0] word_in, [63] zero
    input  logic              i_s_tuser,    // [0] opcode
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [71:0]       i_m_tdata,    // [62:0] word_out, [68:63] syndrome, [71:69] zero
    input  logic [1:0]        i_m_tuser,    // [1:0] status
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_code_len    // n under the current data_bits
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [SYN_W-1:0]  syn;
        t_status           status;
    } t_hsec_result;

    logic [CFG_W-1:0] r_data_bits;
    t_hsec_result     awaited_results[$];
    int               err_cnt;
    int               checked_cnt;

    function automatic int check_bits_for(input int k);
        int r;
        r = 0;
        while ((1 << r) < k + r + 1) begin
            r++;
        end
        return r;
    endfunction

    // zero acts as one; clamp until the code fits
    function automatic int data_len(input logic [CFG_W-1:0] v);
        int k;
        k = int'(v);
        if (k == 0) begin
            k = 1;
        end
        while (k > 1 && k + check_bits_for(k) > MAX_CODE_BITS) begin
            k--;
        end
        return k;
    endfunction

    function automatic bit is_check_pos(input int i);
        return (i & (i - 1)) == 0;
    endfunction

    function automatic t_hsec_result hamming_result(input t_op op,
                                                    input logic [WORD_W-1:0] w,
                                                    input int k);
        t_hsec_result      res;
        logic [WORD_W-1:0] code;
        int                n;
        int                j;
        int                par;
        int                syn;
        n   = k + check_bits_for(k);
        res = '0;
        res.status = ST_CLEAN;
        j   = 1;
        par = 0;
        syn = 0;
        if (op == OP_ENCODE) begin
            for (int i = 1; i <= n; i++) begin
                if (!is_check_pos(i)) begin
                    if (w[j-1]) begin
                        res.word[i-1] = 1'b1;
                        par ^= i;
                    end
                    j++;
                end
            end
            // check bit p takes the parity of its group
            for (int p = 1; p <= n; p = p << 1) begin
                if ((par & p) != 0) begin
                    res.word[p-1] = 1'b1;
                end
            end
        end else begin
            for (int i = 1; i <= n; i++) begin
                if (w[i-1]) begin
                    syn ^= i;
                end
            end
            code = w;
            if (syn != 0) begin
                if (syn <= n) begin
                    code[syn-1] = ~code[syn-1];
                    res.status  = ST_CORRECTED;
                end else begin
                    res.status = ST_BEYOND;
                end
            end
            for (int i = 1; i <= n; i++) begin
                if (!is_check_pos(i)) begin
                    if (code[i-1]) begin
                        res.word[j-1] = 1'b1;
                    end
                    j++;
                end
            end
            res.syn = SYN_W'(syn);
        end
        return res;
    endfunction

    always_comb begin
        o_code_len = data_len(r_data_bits) + check_bits_for(data_len(r_data_bits));
    end

    always @(posedge i_clk) begin
        t_hsec_result got;
        t_hsec_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            r_data_bits <= DATA_BITS_RST;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.word   = i_m_tdata[WORD_W-1:0];
                got.syn    = i_m_tdata[WORD_W+SYN_W-1:WORD_W];
                got.status = t_status'(i_m_tuser);
                checked_cnt++;
                if (awaited_results.size() == 0) begin
                    err_cnt++;
                    $error("unexpected result word: word_out %h", got.word);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.word !== want.word) begin
                        err_cnt++;
                        $error("word_out: expected %h, got %h", want.word, got.word);
                    end
                    if (got.syn !== want.syn) begin
                        err_cnt++;
                        $error("syndrome: expected %0d, got %0d", want.syn, got.syn);
                    end
                    if (got.status !== want.status) begin
                        err_cnt++;
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(hamming_result(t_op'(i_s_tuser),
                                                         i_s_tdata[WORD_W-1:0],
                                                         data_len(r_data_bits)));
            end
            if (i_cfg_we) begin
                r_data_bits <= i_cfg_data;
            end
        end
        o_pending = awaited_results.size();
        o_errors  = err_cnt;
        o_checked = checked_cnt;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the hamming_sec_encode_decode bench: clock, reset, stimulus and verdict.
// Depends on hsec_pkg, hsec_checker and the block itself.
module tb;
    import hsec_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // quiet cycles before the watchdog fires
    localparam int HOLD_CYCLES  = 250;   // long output stall
    localparam int WORDS_EACH   = 95;    // random words per data_bits setting
    localparam int NUM_SETTINGS = 13;    // last one is drawn at random
    localparam int DRAIN_CYCLES = 8;     // pipeline is three deep

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [63:0]       i_s_tdata;    // [62:0] word_in, [63] zero
    logic              i_s_tuser;    // [0] opcode
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [71:0]       o_m_tdata;    // [62:0] word_out, [68:63] syndrome, [71:69] zero
    logic [1:0]        o_m_tuser;    // [1:0] status

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_code_len;

    bit no_idle;        // both sides stream without gaps
    bit hold_req;       // ask the receiver for one long stall
    int hold_left;
    int quiet_cycles;
    int encodes_sent;
    int decodes_sent;

    // data_bits sweep: reset value first, then both extremes, clamped values,
    // lengths whose code is not full (syndromes beyond n possible), and small k
    logic [CFG_W-1:0] setting_list [NUM_SETTINGS] = '{
        6'd57, 6'd0, 6'd1, 6'd5, 6'd63, 6'd58, 6'd2, 6'd26, 6'd11, 6'd4, 6'd56, 6'd32, 6'd0
    };

    hamming_sec_encode_decode dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    hsec_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked),
        .o_code_len (chk_code_len)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver: random back-pressure, one long stall on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= no_idle || ($urandom_range(99) >= 26);
            end
        end
    end

    // watchdog: any accepted word or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("** hamming_sec_encode_decode: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] len_mask(input int n);
        logic [63:0] m;
        m = (64'd1 << n) - 64'd1;
        return m[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] pos_bit(input int pos);
        return WORD_W'(1) << (pos - 1);
    endfunction

    // random content over positions 1..n, then check bits fixed up so the
    // syndrome comes out zero (flipping position 2^m toggles syndrome bit m)
    function automatic logic [WORD_W-1:0] clean_codeword(input int n);
        logic [WORD_W-1:0] w;
        int                syn;
        w   = rand_word() & len_mask(n);
        syn = 0;
        for (int i = 1; i <= n; i++) begin
            if (w[i-1]) begin
                syn ^= i;
            end
        end
        for (int p = 1; p <= n; p = p << 1) begin
            if ((syn & p) != 0) begin
                w[p-1] = ~w[p-1];
            end
        end
        return w;
    endfunction

    // present one word; returns at the falling edge after it was taken
    task automatic send_word(input t_op op, input logic [WORD_W-1:0] w);
        while (!no_idle && $urandom_range(99) < 26) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, w};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        if (op == OP_ENCODE) begin
            encodes_sent++;
        end else begin
            decodes_sent++;
        end
    endtask

    // stop offering and wait for every awaited result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_data_bits(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // edge cases for the current code length
    task automatic send_directed(input int n);
        logic [WORD_W-1:0] cw;
        int                p;
        send_word(OP_ENCODE, '0);
        send_word(OP_ENCODE, '1);                 // data bits above k ignored
        send_word(OP_DECODE, '0);
        send_word(OP_DECODE, '1);                 // codeword bits above n ignored
        cw = clean_codeword(n);
        send_word(OP_DECODE, cw);                 // clean
        send_word(OP_DECODE, cw ^ pos_bit(1));    // error on a check bit
        send_word(OP_DECODE, cw ^ pos_bit(3));    // error on the first data bit
        send_word(OP_DECODE, cw ^ pos_bit(n));    // error on the last position
        send_word(OP_DECODE, cw | ~len_mask(n));  // noise above n only
        // two flips whose syndrome is n+1: only possible when the code is not full
        p = 1;
        while (p * 2 <= n) begin
            p = p * 2;
        end
        if (n + 1 != 2 * p) begin
            send_word(OP_DECODE, cw ^ pos_bit(p) ^ pos_bit(n + 1 - p));
        end
    endtask

    // random data for encode; for decode mostly well-formed codewords with zero, one or two flips, some raw noise
    task automatic send_random_word(input int n);
        logic [WORD_W-1:0] w;
        int                sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            send_word(OP_ENCODE, rand_word());
        end else begin
            if (sel < 60) begin
                w = rand_word();
            end else begin
                w = clean_codeword(n);
                if (sel >= 70) begin
                    w ^= pos_bit($urandom_range(1, n));
                end
                if (sel >= 92) begin
                    w ^= pos_bit($urandom_range(1, n));
                end
                if ($urandom_range(3) == 0) begin
                    w |= rand_word() & ~len_mask(n);
                end
            end
            send_word(OP_DECODE, w);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_ENCODE;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            // phase 0 runs on the reset value of data_bits
            if (ph == NUM_SETTINGS - 1) begin
                write_data_bits(CFG_W'($urandom_range(1, 63)));
            end else if (ph > 0) begin
                write_data_bits(setting_list[ph]);
            end
            no_idle = (ph == 7);
            if (ph == 0 || ph == 3) begin
                send_directed(chk_code_len);
            end
            for (int it = 0; it < WORDS_EACH; it++) begin
                if (ph == 1 && it == 20) begin
                    hold_req = 1'b1;    // sender keeps going, pipeline fills
                end
                if (ph == 4 && it == 50) begin
                    drain();            // sender pause until all results are back
                end
                send_random_word(chk_code_len);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d encode and %0d decode words over %0d data_bits settings,",
                 encodes_sent, decodes_sent, NUM_SETTINGS);
        $display("%0d result words compared, with one %0d-cycle output stall.",
                 chk_checked, HOLD_CYCLES);
        if (chk_pending != 0) begin
            $error("%0d expected result words never arrived", chk_pending);
        end
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("** hamming_sec_encode_decode: PASSED **");
        end else begin
            $display("** hamming_sec_encode_decode: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
src/hsec_pkg.sv
src/hsec_parity.sv
src/hamming_sec_encode_decode.sv
bench/hsec_checker.sv
bench/tb.sv
